// ----- rtl/mspid_pkg.sv -----
`default_nettype none

package mspid_pkg;

  localparam int unsigned PULSE_W   = 13;
  localparam int unsigned SPEED_W   = 12;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned DUTY_W    = 14;
  localparam int unsigned CLASS_W   = 2;

  // e0 spans target - pulse, e1 and e2 add one and two more bits of headroom
  localparam int unsigned ERR0_W    = 14;
  localparam int unsigned ERR1_W    = 15;
  localparam int unsigned ERR2_W    = 16;
  localparam int unsigned PROD_W    = 33;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned INC_W     = SUM_W - FRAC_W;
  localparam int unsigned DRIVE_W   = 15;

  localparam int unsigned DRIVE_LIMIT_DEF = 9999;

  localparam logic [SPEED_W-1:0] OBSTACLE_SPEED = SPEED_W'(80);
  localparam logic [SPEED_W-1:0] RING_SPEED     = SPEED_W'(90);

  localparam logic [CLASS_W-1:0] CLASS_SHORT = CLASS_W'(1);
  localparam logic [CLASS_W-1:0] CLASS_LONG  = CLASS_W'(2);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_LONG_SPEED    = 3'd3,
    REG_SHORT_SPEED   = 3'd4,
    REG_BASE_SPEED    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ERR0_W-1:0] e0;
    logic signed [ERR1_W-1:0] e1;
    logic signed [ERR2_W-1:0] e2;
    logic        [SPEED_W-1:0] target;
  } err_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] i;
    logic signed [PROD_W-1:0] d;
    logic        [SPEED_W-1:0] target;
  } prod_t;

  typedef struct packed {
    logic signed [INC_W-1:0]  inc;
    logic        [SPEED_W-1:0] target;
  } inc_t;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic [SPEED_W-1:0] long_speed;
    logic [SPEED_W-1:0] short_speed;
    logic [SPEED_W-1:0] base_speed;
  } speeds_t;

endpackage

`default_nettype wire

// ----- rtl/mspid_err.sv -----
`default_nettype none

module mspid_err (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output      logic                                  ready_o,
  input  wire logic signed [mspid_pkg::PULSE_W-1:0]  pulse_count_i,
  input  wire logic                                  obstacle_i,
  input  wire logic                                  ring_left_i,
  input  wire logic                                  ring_right_i,
  input  wire logic        [mspid_pkg::CLASS_W-1:0]  straight_class_i,
  input  wire logic                                  stop_request_i,
  input  wire mspid_pkg::speeds_t                    speeds_i,
  output      logic                                  valid_o,
  input  wire logic                                  ready_i,
  output      mspid_pkg::err_t                       data_o
);

  logic                                   valid_q;
  mspid_pkg::err_t                        data_q;
  mspid_pkg::err_t                        data_d;
  logic signed [mspid_pkg::ERR0_W-1:0]    last_err_q;
  logic signed [mspid_pkg::ERR0_W-1:0]    prev_err_q;
  logic                                   zeroed_q;
  logic                                   accept;
  logic        [mspid_pkg::SPEED_W-1:0]   target;
  logic signed [mspid_pkg::ERR0_W-1:0]    e0;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    if (stop_request_i) begin
      target = '0;
    end else if (obstacle_i) begin
      target = mspid_pkg::OBSTACLE_SPEED;
    end else if (ring_left_i || ring_right_i) begin
      target = mspid_pkg::RING_SPEED;
    end else if (straight_class_i == mspid_pkg::CLASS_LONG) begin
      target = speeds_i.long_speed;
    end else if (straight_class_i == mspid_pkg::CLASS_SHORT) begin
      target = zeroed_q ? '0 : speeds_i.short_speed;
    end else begin
      target = zeroed_q ? '0 : speeds_i.base_speed;
    end
  end

  assign e0 = $signed(mspid_pkg::ERR0_W'(target)) - mspid_pkg::ERR0_W'(pulse_count_i);

  always_comb begin
    data_d.target = target;
    data_d.e0     = e0;
    data_d.e1     = mspid_pkg::ERR1_W'(e0) - mspid_pkg::ERR1_W'(last_err_q);
    data_d.e2     = mspid_pkg::ERR2_W'(e0) - (mspid_pkg::ERR2_W'(last_err_q) <<< 1)
                    + mspid_pkg::ERR2_W'(prev_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_err_q <= '0;
      prev_err_q <= '0;
      zeroed_q   <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        last_err_q <= e0;
        prev_err_q <= last_err_q;
        // stop latches for good
        zeroed_q   <= zeroed_q | stop_request_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/mspid_mul.sv -----
`default_nettype none

module mspid_mul (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output      logic             ready_o,
  input  wire mspid_pkg::err_t  data_i,
  input  wire mspid_pkg::gains_t gains_i,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      mspid_pkg::prod_t data_o
);

  localparam int unsigned PW = mspid_pkg::PROD_W;

  logic             valid_q;
  mspid_pkg::prod_t data_q;
  mspid_pkg::prod_t data_d;
  logic             accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // gains are unsigned: zero-extend, errors sign-extend
  always_comb begin
    data_d.target = data_i.target;
    data_d.p = $signed(PW'(gains_i.p)) * PW'(data_i.e1);
    data_d.i = $signed(PW'(gains_i.i)) * PW'(data_i.e0);
    data_d.d = $signed(PW'(gains_i.d)) * PW'(data_i.e2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/mspid_sum.sv -----
`default_nettype none

module mspid_sum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output      logic             ready_o,
  input  wire mspid_pkg::prod_t data_i,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      mspid_pkg::inc_t  data_o
);

  localparam int unsigned SW = mspid_pkg::SUM_W;

  logic                   valid_q;
  mspid_pkg::inc_t        data_q;
  mspid_pkg::inc_t        data_d;
  logic                   accept;
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   sum_adj;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign sum = SW'(data_i.p) + SW'(data_i.i) + SW'(data_i.d);

  // bias negatives so the shift truncates toward zero
  assign sum_adj = sum[SW-1] ? sum + SW'((1 << mspid_pkg::FRAC_W) - 1) : sum;

  always_comb begin
    data_d.target = data_i.target;
    data_d.inc    = sum_adj[SW-1:mspid_pkg::FRAC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/mspid_acc.sv -----
`default_nettype none

module mspid_acc #(
  parameter int unsigned DRIVE_LIMIT = mspid_pkg::DRIVE_LIMIT_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output      logic                               ready_o,
  input  wire mspid_pkg::inc_t                    data_i,
  output      logic                               valid_o,
  input  wire logic                               ready_i,
  output      logic [mspid_pkg::DUTY_W-1:0]       duty_o,
  output      logic                               forward_o,
  output      logic [mspid_pkg::SPEED_W-1:0]      target_speed_o
);

  localparam int unsigned AW = mspid_pkg::INC_W + 1;
  localparam int unsigned DW = mspid_pkg::DRIVE_W;
  localparam logic signed [AW-1:0] LIM_POS = AW'(DRIVE_LIMIT);
  localparam logic signed [AW-1:0] LIM_NEG = -AW'(DRIVE_LIMIT);

  logic                                valid_q;
  logic                                accept;
  logic signed [DW-1:0]                drive_q;
  logic signed [DW-1:0]                drive_d;
  logic signed [AW-1:0]                acc;
  logic [mspid_pkg::DUTY_W-1:0]        duty_q;
  logic                                forward_q;
  logic [mspid_pkg::SPEED_W-1:0]       target_q;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign acc = AW'(drive_q) + AW'(data_i.inc);

  always_comb begin
    if (acc > LIM_POS) begin
      drive_d = DW'(LIM_POS);
    end else if (acc < LIM_NEG) begin
      drive_d = DW'(LIM_NEG);
    end else begin
      drive_d = acc[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      drive_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      forward_q <= !drive_d[DW-1];
      duty_q    <= drive_d[DW-1] ? mspid_pkg::DUTY_W'(-drive_d)
                                 : mspid_pkg::DUTY_W'(drive_d);
      target_q  <= data_i.target;
    end
  end

  assign valid_o        = valid_q;
  assign duty_o         = duty_q;
  assign forward_o      = forward_q;
  assign target_speed_o = target_q;

endmodule

`default_nettype wire

// ----- rtl/motor_speed_incremental_pid_top.sv -----
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid_i/in_ready_o  pulse_count, obstacle, ring flags, class, stop
// out      output     out_valid_o/out_ready_i duty, forward, target_speed
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (always ready)
//
// One beat per cycle in and out while the output is not stalled.
// Four stages: target and errors, three gain products, sum and truncate, drive
// accumulate with clamp into the output register. Each stage holds on its own,
// so bubbles close up while the output is stalled. Reset clears the error
// history, drive, stop latch, valid and config registers to zero, not the data registers.
`default_nettype none

module motor_speed_incremental_pid_top #(
  parameter int unsigned DRIVE_LIMIT = mspid_pkg::DRIVE_LIMIT_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_ready_o,
  input  wire logic signed [mspid_pkg::PULSE_W-1:0]   pulse_count_i,
  input  wire logic                                   obstacle_i,
  input  wire logic                                   ring_left_i,
  input  wire logic                                   ring_right_i,
  input  wire logic        [mspid_pkg::CLASS_W-1:0]   straight_class_i,
  input  wire logic                                   stop_request_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_ready_i,
  output      logic        [mspid_pkg::DUTY_W-1:0]    duty_o,
  output      logic                                   forward_o,
  output      logic        [mspid_pkg::SPEED_W-1:0]   target_speed_o,
  input  wire logic                                   cfg_valid_i,
  output      logic                                   cfg_ready_o,
  input  wire logic        [mspid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [mspid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mspid_pkg::gains_t  gains_q;
  mspid_pkg::speeds_t speeds_q;

  logic             err_valid;
  logic             err_ready;
  mspid_pkg::err_t  err_data;
  logic             mul_valid;
  logic             mul_ready;
  mspid_pkg::prod_t mul_data;
  logic             sum_valid;
  logic             sum_ready;
  mspid_pkg::inc_t  sum_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q  <= '0;
      speeds_q <= '0;
    end else if (cfg_valid_i) begin
      case (mspid_pkg::cfg_reg_e'(cfg_index_i))
        mspid_pkg::REG_GAIN_P:      gains_q.p <= cfg_data_i;
        mspid_pkg::REG_GAIN_I:      gains_q.i <= cfg_data_i;
        mspid_pkg::REG_GAIN_D:      gains_q.d <= cfg_data_i;
        mspid_pkg::REG_LONG_SPEED:  speeds_q.long_speed  <= cfg_data_i[mspid_pkg::SPEED_W-1:0];
        mspid_pkg::REG_SHORT_SPEED: speeds_q.short_speed <= cfg_data_i[mspid_pkg::SPEED_W-1:0];
        mspid_pkg::REG_BASE_SPEED:  speeds_q.base_speed  <= cfg_data_i[mspid_pkg::SPEED_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  mspid_err u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .pulse_count_i    (pulse_count_i),
    .obstacle_i       (obstacle_i),
    .ring_left_i      (ring_left_i),
    .ring_right_i     (ring_right_i),
    .straight_class_i (straight_class_i),
    .stop_request_i   (stop_request_i),
    .speeds_i         (speeds_q),
    .valid_o          (err_valid),
    .ready_i          (err_ready),
    .data_o           (err_data)
  );

  mspid_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .data_i  (err_data),
    .gains_i (gains_q),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  mspid_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  mspid_acc #(
    .DRIVE_LIMIT (DRIVE_LIMIT)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (sum_valid),
    .ready_o        (sum_ready),
    .data_i         (sum_data),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .duty_o         (duty_o),
    .forward_o      (forward_o),
    .target_speed_o (target_speed_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb_motor_speed_incremental_pid_top.sv -----
`timescale 1ns / 100ps

module tb_motor_speed_incremental_pid_top;
  import mspid_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int          DUTY_LIMIT    = int'(DRIVE_LIMIT_DEF);

  localparam logic [CLASS_W-1:0]   CLASS_NONE     = CLASS_W'(0);
  localparam logic [CLASS_W-1:0]   CLASS_SPARE    = CLASS_W'(3);
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_6 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_7 = CFG_IDX_W'(7);

  typedef struct {
    logic signed [PULSE_W-1:0] pulse;
    logic                      obstacle;
    logic                      ring_l;
    logic                      ring_r;
    logic        [CLASS_W-1:0] cls;
    logic                      stop;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0]  duty;
    logic               fwd;
    logic [SPEED_W-1:0] target;
  } duty_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [PULSE_W-1:0]    pulse_count = '0;
  logic                         obstacle = 1'b0;
  logic                         ring_left = 1'b0;
  logic                         ring_right = 1'b0;
  logic        [CLASS_W-1:0]    straight_class = '0;
  logic                         stop_request = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic        [DUTY_W-1:0]     duty;
  logic                         forward;
  logic        [SPEED_W-1:0]    target_speed;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow and loop state of the predictor
  logic [GAIN_W-1:0]  kp = '0, ki = '0, kd = '0;
  logic [SPEED_W-1:0] long_spd = '0, short_spd = '0, base_spd = '0;
  int                 err_last = 0, err_prev = 0, drive_acc = 0;
  bit                 brake_latched = 1'b0;

  duty_result_t pending_duty_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;
  int unsigned  hold_req = 0, hold_ack = 0, hold_left = 0;

  motor_speed_incremental_pid_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .pulse_count_i    (pulse_count),
    .obstacle_i       (obstacle),
    .ring_left_i      (ring_left),
    .ring_right_i     (ring_right),
    .straight_class_i (straight_class),
    .stop_request_i   (stop_request),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .duty_o           (duty),
    .forward_o        (forward),
    .target_speed_o   (target_speed),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Target choice, velocity-form update and clamp for one tick
  function automatic duty_result_t advance_speed_loop(tick_t t);
    logic [SPEED_W-1:0] tgt;
    int                 e0, e1, e2;
    longint             weighted, delta, acc;
    duty_result_t       r;
    if (t.stop) begin
      tgt = '0;
      brake_latched = 1'b1;
    end else if (t.obstacle) begin
      tgt = OBSTACLE_SPEED;
    end else if (t.ring_l || t.ring_r) begin
      tgt = RING_SPEED;
    end else if (t.cls == CLASS_LONG) begin
      tgt = long_spd;
    end else if (t.cls == CLASS_SHORT) begin
      tgt = brake_latched ? '0 : short_spd;
    end else begin
      tgt = brake_latched ? '0 : base_spd;
    end
    e0 = int'(tgt) - int'($signed(t.pulse));
    e1 = e0 - err_last;
    e2 = e0 - 2 * err_last + err_prev;
    err_prev = err_last;
    err_last = e0;
    weighted = longint'(kp) * longint'(e1) + longint'(ki) * longint'(e0)
             + longint'(kd) * longint'(e2);
    delta = weighted / 256;
    acc = longint'(drive_acc) + delta;
    if (acc > DUTY_LIMIT) acc = DUTY_LIMIT;
    if (acc < -DUTY_LIMIT) acc = -DUTY_LIMIT;
    drive_acc = int'(acc);
    if (drive_acc >= 0) begin
      r.duty = DUTY_W'(drive_acc);
      r.fwd  = 1'b1;
    end else begin
      r.duty = DUTY_W'(-drive_acc);
      r.fwd  = 1'b0;
    end
    r.target = tgt;
    return r;
  endfunction

  function automatic tick_t make_tick(int pulse, bit obs, bit rl, bit rr,
                                      logic [CLASS_W-1:0] cls, bit stp);
    tick_t t;
    t.pulse    = PULSE_W'(pulse);
    t.obstacle = obs;
    t.ring_l   = rl;
    t.ring_r   = rr;
    t.cls      = cls;
    t.stop     = stp;
    return t;
  endfunction

  function automatic tick_t rand_tick(bit allow_stop);
    int    v;
    tick_t t;
    case ($urandom_range(7))
      0:       v = $urandom_range(1) ? -4096 : 4095;
      1, 2, 3: v = int'($urandom_range(8191)) - 4096;
      default: v = int'($urandom_range(700)) - 100;
    endcase
    t.pulse    = PULSE_W'(v);
    t.obstacle = ($urandom_range(7) == 0);
    t.ring_l   = ($urandom_range(7) == 0);
    t.ring_r   = ($urandom_range(7) == 0);
    t.cls      = CLASS_W'($urandom_range(3));
    t.stop     = allow_stop && ($urandom_range(9) == 0);
    return t;
  endfunction

  // speed registers ignore the top bits of the data word, so fill them with noise
  function automatic logic [CFG_DATA_W-1:0] pad_speed(logic [SPEED_W-1:0] spd);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    return {noise[CFG_DATA_W-1:SPEED_W], spd};
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = 0;
    in_valid       <= 1'b1;
    pulse_count    <= t.pulse;
    obstacle       <= t.obstacle;
    ring_left      <= t.ring_l;
    ring_right     <= t.ring_r;
    straight_class <= t.cls;
    stop_request   <= t.stop;
    do @(posedge clk); while (!in_ready);
    pending_duty_q.push_back(advance_speed_loop(t));
    if (!calm) begin
      while ($urandom_range(99) < 30) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_ticks(int unsigned n, bit allow_stop);
    repeat (n) send_tick(rand_tick(allow_stop));
  endtask

  // drop valid and wait until every predicted beat has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last_beat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_P:      kp = data;
      REG_GAIN_I:      ki = data;
      REG_GAIN_D:      kd = data;
      REG_LONG_SPEED:  long_spd = data[SPEED_W-1:0];
      REG_SHORT_SPEED: short_spd = data[SPEED_W-1:0];
      REG_BASE_SPEED:  base_spd = data[SPEED_W-1:0];
      default: ;
    endcase
    if (last_beat) cfg_valid <= 1'b0;
  endtask

  task automatic program_loop(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                              logic [GAIN_W-1:0] gd, logic [SPEED_W-1:0] ls,
                              logic [SPEED_W-1:0] ss, logic [SPEED_W-1:0] bs);
    settle();
    write_reg(REG_GAIN_P, gp, 1'b0);
    write_reg(REG_GAIN_I, gi, 1'b0);
    write_reg(REG_GAIN_D, gd, 1'b0);
    write_reg(REG_LONG_SPEED, pad_speed(ls), 1'b0);
    write_reg(REG_SHORT_SPEED, pad_speed(ss), 1'b0);
    write_reg(REG_BASE_SPEED, pad_speed(bs), 1'b1);
  endtask

  task automatic program_random(logic [GAIN_W-1:0] gain_max);
    program_loop(GAIN_W'($urandom_range(gain_max)), GAIN_W'($urandom_range(gain_max)),
                 GAIN_W'($urandom_range(gain_max)), SPEED_W'($urandom_range(4095)),
                 SPEED_W'($urandom_range(4095)), SPEED_W'($urandom_range(4095)));
  endtask

  task automatic test_reset_defaults();
    send_tick(make_tick(100, 1'b1, 1'b0, 1'b0, CLASS_NONE, 1'b0));
    send_tick(make_tick(-100, 1'b0, 1'b1, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(100, 1'b0, 1'b0, 1'b0, CLASS_SHORT, 1'b0));
  endtask

  task automatic test_target_priority();
    program_loop(16'h0100, 16'h0040, 16'h0020, 12'd1234, 12'd567, 12'hFFF);
    send_tick(make_tick(3000, 1'b1, 1'b1, 1'b1, CLASS_LONG, 1'b0));
    send_tick(make_tick(0, 1'b0, 1'b1, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(0, 1'b0, 1'b0, 1'b1, CLASS_SHORT, 1'b0));
    send_tick(make_tick(500, 1'b0, 1'b0, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(500, 1'b0, 1'b0, 1'b0, CLASS_SHORT, 1'b0));
    send_tick(make_tick(500, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
    send_tick(make_tick(500, 1'b0, 1'b0, 1'b0, CLASS_SPARE, 1'b0));
    send_tick(make_tick(-4096, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
    send_tick(make_tick(4095, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
  endtask

  // writes past the last register must leave every setting alone
  task automatic test_unmapped_index();
    settle();
    write_reg(IDX_UNMAPPED_6, 16'hFFFF, 1'b0);
    write_reg(IDX_UNMAPPED_7, CFG_DATA_W'($urandom), 1'b1);
    send_tick(make_tick(200, 1'b0, 1'b0, 1'b0, CLASS_SHORT, 1'b0));
    send_tick(make_tick(200, 1'b0, 1'b0, 1'b0, CLASS_LONG, 1'b0));
  endtask

  task automatic test_saturation();
    program_loop(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'd0, 12'd0);
    send_tick(make_tick(-4096, 1'b0, 1'b0, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(-4096, 1'b0, 1'b0, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(4095, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
    send_tick(make_tick(4095, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
  endtask

  // hold the result side while beats keep coming, so the pipe fills and stalls
  task automatic test_backpressure();
    program_random(16'h0300);
    calm = 1'b1;
    hold_req++;
    run_ticks(40, 1'b0);
    calm = 1'b0;
  endtask

  task automatic test_random_sweep();
    program_random(16'h0300);
    run_ticks(200, 1'b0);
    program_loop(16'hFFFF, 16'h0000, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    run_ticks(150, 1'b0);
    program_random(16'hFFFF);
    calm = 1'b1;
    run_ticks(200, 1'b0);
    calm = 1'b0;
    program_loop(16'h0000, 16'h0000, 16'h0000, 12'd0, 12'd0, 12'd0);
    run_ticks(100, 1'b0);
    program_random(16'h0300);
    run_ticks(300, 1'b0);
  endtask

  task automatic test_stop_latch();
    program_loop(16'h0080, 16'h0020, 16'h0010, 12'd700, 12'd300, 12'd200);
    send_tick(make_tick(50, 1'b1, 1'b1, 1'b1, CLASS_LONG, 1'b1));
    send_tick(make_tick(50, 1'b0, 1'b0, 1'b0, CLASS_LONG, 1'b0));
    send_tick(make_tick(50, 1'b0, 1'b0, 1'b0, CLASS_SHORT, 1'b0));
    send_tick(make_tick(50, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
    send_tick(make_tick(50, 1'b0, 1'b0, 1'b0, CLASS_SPARE, 1'b0));
    // a fresh write must not release the latch
    program_loop(16'h0080, 16'h0020, 16'h0010, 12'd700, 12'hFFF, 12'hFFF);
    send_tick(make_tick(-50, 1'b0, 1'b0, 1'b0, CLASS_SHORT, 1'b0));
    send_tick(make_tick(-50, 1'b0, 1'b0, 1'b0, CLASS_NONE, 1'b0));
  endtask

  task automatic test_random_after_stop();
    program_random(16'h0300);
    run_ticks(200, 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin : check_beat
    duty_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_duty_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected beat: duty %0d forward %0b target %0d",
                   duty, forward, target_speed);
      end else begin
        want = pending_duty_q.pop_front();
        if (duty !== want.duty || forward !== want.fwd || target_speed !== want.target) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch (exp/act): duty %0d/%0d forward %0b/%0b target %0d/%0d",
                     want.duty, duty, want.fwd, forward, want.target, target_speed);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_target_priority();
    test_unmapped_index();
    test_saturation();
    test_backpressure();
    test_random_sweep();
    test_stop_latch();
    test_random_after_stop();
    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
